// ----- hdl/eer_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the exponential lookup table of the epidemic event-rate block.
// Depends on nothing; every other file of the block uses it by scoped names.
package eer_pkg;

  // Exponential table: depth must be a power of two between 16 and 4096
  localparam int unsigned ExpTableDepth = 256;
  localparam int unsigned ExpIdxW       = $clog2(ExpTableDepth);
  // Table covers x in [0, 16) as Q.24, i.e. the low 28 bits of the dose
  localparam int unsigned ExpRangeW     = 28;
  localparam int unsigned StepShift     = ExpRangeW - ExpIdxW;
  localparam longint unsigned StepQ24   = (64'd16 << 24) / ExpTableDepth;

  // Emigration rate, unsigned Q8.24
  localparam logic [31:0] EmigrationRateQ24 = 32'd16777;

  // Datapath widths
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned TagW     = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned LoadW    = 24;
  localparam int unsigned DoseW    = CfgW + LoadW;
  localparam int unsigned ExpW     = 31;
  localparam int unsigned DeltaW   = 30;
  localparam int unsigned EnvW     = 32;
  localparam int unsigned DirectW  = CfgW + CountW;
  localparam int unsigned TotalW   = DirectW + 1;
  localparam int unsigned RateW    = 48;
  localparam int unsigned NumStages = 6;

  localparam logic [ExpW-1:0]  OneQ30  = 31'h4000_0000;
  localparam logic [RateW-1:0] RateMax = '1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegContact   = 3'd0,
    RegEnv       = 3'd1,
    RegDose      = 3'd2,
    RegRecovery  = 3'd3,
    RegBaseMort  = 3'd4,
    RegDisMort   = 3'd5,
    RegShedding  = 3'd6,
    RegDecay     = 3'd7
  } cfg_reg_e;

  // Table entry: exp(-k*step) in Q.30 and the drop to the next entry
  typedef logic [ExpW+DeltaW-1:0] exp_entry_t;
  typedef exp_entry_t exp_tab_t [ExpTableDepth];

  // Pipeline control: per-stage load enables and valid bits
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // Unsigned shift-and-subtract quotient, evaluated while the table is built
  function automatic longint unsigned const_udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Build the table: Taylor series for exp(-step), then repeated rounded products
  function automatic exp_tab_t exp_table_build();
    exp_tab_t tab;
    longint unsigned s30;
    longint unsigned term;
    longint unsigned ratio;
    longint unsigned cur;
    longint unsigned nxt;
    longint unsigned dlt;
    longint sum;
    s30  = StepQ24 << 6;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int n = 1; n <= 24; n++) begin
      term = const_udiv(term * s30, 64'(n) << 30);
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    ratio = (sum < 0) ? 64'd0 : longint'(sum);
    cur   = 64'd1 << 30;
    for (int k = 0; k < int'(ExpTableDepth); k++) begin
      nxt    = (cur * ratio + (64'd1 << 29)) >> 30;
      dlt    = cur - nxt;
      tab[k] = {cur[ExpW-1:0], dlt[DeltaW-1:0]};
      cur    = nxt;
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTable = exp_table_build();

endpackage

// ----- hdl/eer_pipe_ctrl.sv -----
`timescale 1ns / 1ps
// Valid bits and per-stage load enables of the rate pipeline.
// Depends on eer_pkg (stage count, pipe_ctl_t).
module eer_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output eer_pkg::pipe_ctl_t ctl_o
);

  logic [eer_pkg::NumStages-1:0] en;
  logic [eer_pkg::NumStages-1:0] vld_q;
  logic [eer_pkg::NumStages-1:0] vld_d;

  // A stage loads when it is empty or its item moves on
  always_comb begin
    en[eer_pkg::NumStages-1] = !vld_q[eer_pkg::NumStages-1] || out_ready_i;
    for (int k = eer_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < int'(eer_pkg::NumStages); k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = en[0];
  assign ctl_o.en   = en;
  assign ctl_o.vld  = vld_q;

endmodule

// ----- hdl/eer_exp_unit.sv -----
`timescale 1ns / 1ps
// Two-stage 1 - exp(-x) unit: table lookup, then linear interpolation.
// Depends on eer_pkg (ExpTable, widths, OneQ30).
module eer_exp_unit (
  input  logic                         clk_i,
  input  logic                         en_lookup_i,
  input  logic                         en_interp_i,
  input  logic [eer_pkg::DoseW-1:0]    dose_i,
  output logic [eer_pkg::ExpW-1:0]     one_minus_exp_o
);

  logic                            over_d;
  logic [eer_pkg::ExpIdxW-1:0]     idx;
  eer_pkg::exp_entry_t             entry;

  logic                            over_q;
  logic [eer_pkg::ExpW-1:0]        tab_q;
  logic [eer_pkg::DeltaW-1:0]      delta_q;
  logic [eer_pkg::StepShift-1:0]   frac_q;

  logic [eer_pkg::DeltaW+eer_pkg::StepShift-1:0] corr_prod;
  logic [eer_pkg::DeltaW-1:0]      corr;
  logic [eer_pkg::ExpW-1:0]        exp_val;
  logic [eer_pkg::ExpW-1:0]        om_d;
  logic [eer_pkg::ExpW-1:0]        om_q;

  // Split the dose into table index and fraction; beyond the table exp is zero
  assign over_d = |dose_i[eer_pkg::DoseW-1:eer_pkg::ExpRangeW];
  assign idx    = dose_i[eer_pkg::ExpRangeW-1:eer_pkg::StepShift];
  assign entry  = eer_pkg::ExpTable[idx];

  always_ff @(posedge clk_i) begin
    if (en_lookup_i) begin
      over_q  <= over_d;
      tab_q   <= entry[eer_pkg::ExpW+eer_pkg::DeltaW-1:eer_pkg::DeltaW];
      delta_q <= entry[eer_pkg::DeltaW-1:0];
      frac_q  <= dose_i[eer_pkg::StepShift-1:0];
    end
  end

  // Interpolate toward the next entry; step is a power of two, so divide by shift
  assign corr_prod = (eer_pkg::DeltaW + eer_pkg::StepShift)'(delta_q)
                   * (eer_pkg::DeltaW + eer_pkg::StepShift)'(frac_q);
  assign corr      = corr_prod[eer_pkg::DeltaW+eer_pkg::StepShift-1:eer_pkg::StepShift];
  assign exp_val   = tab_q - eer_pkg::ExpW'(corr);
  assign om_d      = over_q ? eer_pkg::OneQ30 : (eer_pkg::OneQ30 - exp_val);

  always_ff @(posedge clk_i) begin
    if (en_interp_i) begin
      om_q <= om_d;
    end
  end

  assign one_minus_exp_o = om_q;

endmodule

// ----- hdl/epidemic_event_rates.sv -----
`timescale 1ns / 1ps
// Top level of the epidemic event-rate pipeline: config registers and rate datapath.
// Depends on eer_pkg, eer_pipe_ctrl and eer_exp_unit.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i (3b), cfg_data_i (32b)
//  in      | in        | in_valid_i/in_ready_o   | patch_index_i, susceptible_i, infected_i,
//          |           |                        | recovered_i, virion_load_i
//  out     | out       | out_valid_o/out_ready_i | patch_tag_o and ten 48-bit Q32.16 rates
//
// One item per cycle sustained while out_ready_i is high; each item passes through the register stages
// (dose and direct products, table lookup, interpolation, environmental product,
// sum, final products with saturation) in order. The exponential table is constant logic,
// so no clearing pass follows reset; reset clears the config registers and valid bits.
// A stalled output holds only the stages that are full; empty stages keep loading.
// Config writes are always taken.
module epidemic_event_rates #(
  parameter logic [31:0] EmigrationRateQ24 = eer_pkg::EmigrationRateQ24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [eer_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [eer_pkg::CfgW-1:0]       cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [eer_pkg::TagW-1:0]       patch_index_i,
  input  logic [eer_pkg::CountW-1:0]     susceptible_i,
  input  logic [eer_pkg::CountW-1:0]     infected_i,
  input  logic [eer_pkg::CountW-1:0]     recovered_i,
  input  logic [eer_pkg::LoadW-1:0]      virion_load_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [eer_pkg::TagW-1:0]       patch_tag_o,
  output logic [eer_pkg::RateW-1:0]      infection_o,
  output logic [eer_pkg::RateW-1:0]      recovery_o,
  output logic [eer_pkg::RateW-1:0]      susceptible_death_o,
  output logic [eer_pkg::RateW-1:0]      infected_death_o,
  output logic [eer_pkg::RateW-1:0]      recovered_death_o,
  output logic [eer_pkg::RateW-1:0]      shedding_o,
  output logic [eer_pkg::RateW-1:0]      degradation_o,
  output logic [eer_pkg::RateW-1:0]      susceptible_leave_o,
  output logic [eer_pkg::RateW-1:0]      infected_leave_o,
  output logic [eer_pkg::RateW-1:0]      recovered_leave_o
);

  localparam int unsigned MortW  = eer_pkg::CfgW + 1;
  localparam int unsigned InfW   = eer_pkg::CountW + eer_pkg::TotalW;
  localparam int unsigned EnvPW  = eer_pkg::CfgW + eer_pkg::ExpW;

  typedef struct packed {
    logic [eer_pkg::TagW-1:0]   tag;
    logic [eer_pkg::CountW-1:0] s;
    logic [eer_pkg::CountW-1:0] i;
    logic [eer_pkg::CountW-1:0] r;
    logic [eer_pkg::LoadW-1:0]  v;
  } patch_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [eer_pkg::CfgW-1:0] contact_q, env_rate_q, dose_scale_q, recovery_q;
  logic [eer_pkg::CfgW-1:0] base_mort_q, dis_mort_q, shedding_q, decay_q;
  logic [MortW-1:0]         mort_sum_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q    <= '0;
      env_rate_q   <= '0;
      dose_scale_q <= '0;
      recovery_q   <= '0;
      base_mort_q  <= '0;
      dis_mort_q   <= '0;
      shedding_q   <= '0;
      decay_q      <= '0;
    end else if (cfg_valid_i) begin
      case (eer_pkg::cfg_reg_e'(cfg_index_i))
        eer_pkg::RegContact:  contact_q    <= cfg_data_i;
        eer_pkg::RegEnv:      env_rate_q   <= cfg_data_i;
        eer_pkg::RegDose:     dose_scale_q <= cfg_data_i;
        eer_pkg::RegRecovery: recovery_q   <= cfg_data_i;
        eer_pkg::RegBaseMort: base_mort_q  <= cfg_data_i;
        eer_pkg::RegDisMort:  dis_mort_q   <= cfg_data_i;
        eer_pkg::RegShedding: shedding_q   <= cfg_data_i;
        eer_pkg::RegDecay:    decay_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Keep the infected-host mortality sum ready ahead of the last stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mort_sum_q <= '0;
    end else begin
      mort_sum_q <= MortW'(base_mort_q) + MortW'(dis_mort_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  eer_pkg::pipe_ctl_t ctl;

  eer_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctl_o       (ctl)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: dose and direct-contact products
  // ---------------------------------------------------------------------------
  patch_t                       p1_d, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [eer_pkg::DoseW-1:0]    dose_d, dose_q;
  logic [eer_pkg::DirectW-1:0]  direct_d, direct1_q, direct2_q, direct3_q, direct4_q;

  assign p1_d.tag = patch_index_i;
  assign p1_d.s   = susceptible_i;
  assign p1_d.i   = infected_i;
  assign p1_d.r   = recovered_i;
  assign p1_d.v   = virion_load_i;

  assign dose_d   = eer_pkg::DoseW'(dose_scale_q) * eer_pkg::DoseW'(virion_load_i);
  assign direct_d = eer_pkg::DirectW'(contact_q) * eer_pkg::DirectW'(infected_i);

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      p1_q      <= p1_d;
      dose_q    <= dose_d;
      direct1_q <= direct_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: 1 - exp(-dose) in the exponential unit
  // ---------------------------------------------------------------------------
  logic [eer_pkg::ExpW-1:0] om;

  eer_exp_unit u_exp (
    .clk_i           (clk_i),
    .en_lookup_i     (ctl.en[1]),
    .en_interp_i     (ctl.en[2]),
    .dose_i          (dose_q),
    .one_minus_exp_o (om)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.en[1]) begin
      p2_q      <= p1_q;
      direct2_q <= direct1_q;
    end
    if (ctl.en[2]) begin
      p3_q      <= p2_q;
      direct3_q <= direct2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: environmental infection term
  // ---------------------------------------------------------------------------
  logic [EnvPW-1:0]           env_prod;
  logic [eer_pkg::EnvW-1:0]   env_q;

  assign env_prod = EnvPW'(env_rate_q) * EnvPW'(om);

  always_ff @(posedge clk_i) begin
    if (ctl.en[3]) begin
      p4_q      <= p3_q;
      direct4_q <= direct3_q;
      env_q     <= env_prod[eer_pkg::EnvW+29:30];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: total per-susceptible infection pressure
  // ---------------------------------------------------------------------------
  logic [eer_pkg::TotalW-1:0] total_q;

  always_ff @(posedge clk_i) begin
    if (ctl.en[4]) begin
      p5_q    <= p4_q;
      total_q <= eer_pkg::TotalW'(direct4_q) + eer_pkg::TotalW'(env_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: final products, truncate to Q.16, saturate the infection rate
  // ---------------------------------------------------------------------------
  logic [InfW-1:0]                           inf_prod;
  logic [eer_pkg::CountW+eer_pkg::CfgW-1:0]  rec_prod, sdeath_prod, rdeath_prod, shed_prod;
  logic [eer_pkg::CountW+eer_pkg::CfgW-1:0]  sleave_prod, ileave_prod, rleave_prod;
  logic [eer_pkg::CountW+MortW-1:0]          ideath_prod;
  logic [eer_pkg::DoseW-1:0]                 degr_prod;
  logic [eer_pkg::RateW-1:0]                 inf_d;

  localparam int unsigned NarrowW = eer_pkg::CountW + eer_pkg::CfgW;

  assign inf_prod    = InfW'(p5_q.s) * InfW'(total_q);
  assign inf_d       = (|inf_prod[InfW-1:eer_pkg::RateW+8]) ? eer_pkg::RateMax
                                                            : inf_prod[eer_pkg::RateW+7:8];
  assign rec_prod    = NarrowW'(p5_q.i) * NarrowW'(recovery_q);
  assign sdeath_prod = NarrowW'(p5_q.s) * NarrowW'(base_mort_q);
  assign rdeath_prod = NarrowW'(p5_q.r) * NarrowW'(base_mort_q);
  assign shed_prod   = NarrowW'(p5_q.i) * NarrowW'(shedding_q);
  assign ideath_prod = (eer_pkg::CountW + MortW)'(p5_q.i) * (eer_pkg::CountW + MortW)'(mort_sum_q);
  assign degr_prod   = eer_pkg::DoseW'(p5_q.v) * eer_pkg::DoseW'(decay_q);
  assign sleave_prod = NarrowW'(p5_q.s) * NarrowW'(EmigrationRateQ24);
  assign ileave_prod = NarrowW'(p5_q.i) * NarrowW'(EmigrationRateQ24);
  assign rleave_prod = NarrowW'(p5_q.r) * NarrowW'(EmigrationRateQ24);

  always_ff @(posedge clk_i) begin
    if (ctl.en[5]) begin
      patch_tag_o         <= p5_q.tag;
      infection_o         <= inf_d;
      recovery_o          <= eer_pkg::RateW'(rec_prod >> 8);
      susceptible_death_o <= eer_pkg::RateW'(sdeath_prod >> 8);
      infected_death_o    <= eer_pkg::RateW'(ideath_prod >> 8);
      recovered_death_o   <= eer_pkg::RateW'(rdeath_prod >> 8);
      shedding_o          <= eer_pkg::RateW'(shed_prod >> 8);
      degradation_o       <= eer_pkg::RateW'(degr_prod >> 8);
      susceptible_leave_o <= eer_pkg::RateW'(sleave_prod >> 8);
      infected_leave_o    <= eer_pkg::RateW'(ileave_prod >> 8);
      recovered_leave_o   <= eer_pkg::RateW'(rleave_prod >> 8);
    end
  end

  assign out_valid_o = ctl.vld[eer_pkg::NumStages-1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A consumer that takes results never holds back the input side
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output side is ready");

  // An accepted item occupies the first stage on the next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ctl.vld[0])
    else $error("accepted item missing from first stage");

  // The interpolated complement of exp never exceeds one
  a_om_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.vld[2] |-> (om <= eer_pkg::OneQ30))
    else $error("1 - exp out of range");

  // A stalled result stays valid with its tag unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(patch_tag_o)))
    else $error("stalled result changed");

endmodule

// ----- test/epidemic_event_rates_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for epidemic_event_rates: directed rows, then random patches under
// random rate settings, each result compared field by field with a preset or an in-bench predicted rate set.
// Depends on eer_pkg and the epidemic_event_rates RTL.
module epidemic_event_rates_tb;

  localparam int unsigned Depth      = eer_pkg::ExpTableDepth;
  localparam logic [63:0] TableStep  = (64'd16 << 24) / Depth;
  localparam logic [63:0] Q30One     = 64'd1 << 30;
  localparam logic [47:0] ResetLeave = 48'd4294846;
  localparam int          StallLimit = 4000;
  localparam int          NumRows    = 18;
  localparam int          ScratchSet = 5;

  typedef struct packed {
    logic [eer_pkg::TagW-1:0]   tag;
    logic [eer_pkg::CountW-1:0] susceptible;
    logic [eer_pkg::CountW-1:0] infected;
    logic [eer_pkg::CountW-1:0] recovered;
    logic [eer_pkg::LoadW-1:0]  load;
  } patch_item_t;

  typedef struct packed {
    logic [eer_pkg::TagW-1:0]  tag;
    logic [eer_pkg::RateW-1:0] infection;
    logic [eer_pkg::RateW-1:0] recovery;
    logic [eer_pkg::RateW-1:0] susceptible_death;
    logic [eer_pkg::RateW-1:0] infected_death;
    logic [eer_pkg::RateW-1:0] recovered_death;
    logic [eer_pkg::RateW-1:0] shedding;
    logic [eer_pkg::RateW-1:0] degradation;
    logic [eer_pkg::RateW-1:0] susceptible_leave;
    logic [eer_pkg::RateW-1:0] infected_leave;
    logic [eer_pkg::RateW-1:0] recovered_leave;
  } rate_set_t;

  typedef struct packed {
    logic      typed;
    rate_set_t want;
  } preset_t;

  typedef struct packed {
    logic [2:0]  setting;
    patch_item_t item;
    logic        typed;
    rate_set_t   want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [eer_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [eer_pkg::CfgW-1:0]     cfg_data_i = '0;

  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [eer_pkg::TagW-1:0]     patch_index_i = '0;
  logic [eer_pkg::CountW-1:0]   susceptible_i = '0;
  logic [eer_pkg::CountW-1:0]   infected_i = '0;
  logic [eer_pkg::CountW-1:0]   recovered_i = '0;
  logic [eer_pkg::LoadW-1:0]    virion_load_i = '0;

  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [eer_pkg::TagW-1:0]     patch_tag_o;
  logic [eer_pkg::RateW-1:0]    infection_o;
  logic [eer_pkg::RateW-1:0]    recovery_o;
  logic [eer_pkg::RateW-1:0]    susceptible_death_o;
  logic [eer_pkg::RateW-1:0]    infected_death_o;
  logic [eer_pkg::RateW-1:0]    recovered_death_o;
  logic [eer_pkg::RateW-1:0]    shedding_o;
  logic [eer_pkg::RateW-1:0]    degradation_o;
  logic [eer_pkg::RateW-1:0]    susceptible_leave_o;
  logic [eer_pkg::RateW-1:0]    infected_leave_o;
  logic [eer_pkg::RateW-1:0]    recovered_leave_o;

  // Bench copy of the rate registers and of the exp(-x) table in Q.30
  logic [31:0] cfg_shadow [8];
  logic [63:0] decay_q30 [Depth+1];

  rate_set_t expected_rates_q [$];
  preset_t   typed_wants_q [$];
  int        mismatches = 0;
  int        results_seen = 0;

  // Register values by index: reset, all ones, three dose-focused sets, random scratch
  logic [31:0] settings [6][8] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h0000_4000, 32'h0200_0000, 32'h0123_4567, 32'h0040_0000,
      32'h0001_0000, 32'h0008_0000, 32'h0A00_0000, 32'h0000_8000},
    '{32'h0000_4000, 32'h0200_0000, 32'h0010_0000, 32'h0040_0000,
      32'h0001_0000, 32'h0008_0000, 32'h0A00_0000, 32'h0000_8000},
    '{32'h0, 32'hFFFF_FFFF, 32'h0FF8_0000, 32'h0100_0000,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0100_0000},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}
  };

  // Directed rows: reset state, saturation, zero dose, interpolation, table edges
  directed_row_t dir_rows [NumRows] = '{
    '{3'd0, '{10'd0, 16'h0, 16'h0, 16'h0, 24'h0}, 1'b1, '0},
    '{3'd0, '{10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF}, 1'b1,
      '{10'd1023, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0,
        ResetLeave, ResetLeave, ResetLeave}},
    '{3'd0, '{10'd341, 16'hAAAA, 16'h5555, 16'h00FF, 24'hA5_A5A5}, 1'b0, '0},
    '{3'd1, '{10'd1, 16'h0, 16'h0, 16'h0, 24'h0}, 1'b0, '0},
    '{3'd1, '{10'd1022, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF}, 1'b0, '0},
    '{3'd1, '{10'd2, 16'hFFFF, 16'h0, 16'h0, 24'h0}, 1'b0, '0},
    '{3'd1, '{10'd3, 16'h1, 16'h1, 16'h1, 24'h1}, 1'b0, '0},
    '{3'd1, '{10'd4, 16'hFFFF, 16'h1, 16'h0, 24'h0}, 1'b0, '0},
    '{3'd1, '{10'd5, 16'h0, 16'hFFFF, 16'h0, 24'hFF_FFFF}, 1'b0, '0},
    '{3'd2, '{10'd6, 16'd1000, 16'd20, 16'd300, 24'd0}, 1'b0, '0},
    '{3'd2, '{10'd7, 16'd1000, 16'd20, 16'd300, 24'd1}, 1'b0, '0},
    '{3'd2, '{10'd8, 16'd5000, 16'd0, 16'd10, 24'd14}, 1'b0, '0},
    '{3'd2, '{10'd9, 16'd5000, 16'd0, 16'd10, 24'd15}, 1'b0, '0},
    '{3'd3, '{10'd10, 16'd800, 16'd3, 16'd0, 24'd0}, 1'b0, '0},
    '{3'd3, '{10'd11, 16'd800, 16'd3, 16'd0, 24'd255}, 1'b0, '0},
    '{3'd3, '{10'd12, 16'd800, 16'd3, 16'd0, 24'd256}, 1'b0, '0},
    '{3'd4, '{10'd13, 16'hFFFF, 16'h0, 16'h0, 24'd1}, 1'b0, '0},
    '{3'd4, '{10'd14, 16'd1234, 16'd4321, 16'd999, 24'd2}, 1'b0, '0}
  };

  epidemic_event_rates i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .patch_index_i       (patch_index_i),
    .susceptible_i       (susceptible_i),
    .infected_i          (infected_i),
    .recovered_i         (recovered_i),
    .virion_load_i       (virion_load_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .patch_tag_o         (patch_tag_o),
    .infection_o         (infection_o),
    .recovery_o          (recovery_o),
    .susceptible_death_o (susceptible_death_o),
    .infected_death_o    (infected_death_o),
    .recovered_death_o   (recovered_death_o),
    .shedding_o          (shedding_o),
    .degradation_o       (degradation_o),
    .susceptible_leave_o (susceptible_leave_o),
    .infected_leave_o    (infected_leave_o),
    .recovered_leave_o   (recovered_leave_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Fill the exp(-k*step) table: Taylor series for the step ratio, then rounded products
  function automatic void build_decay_table();
    logic [63:0] s30;
    logic [63:0] term;
    logic [63:0] pos_sum;
    logic [63:0] neg_sum;
    logic [63:0] ratio;
    s30     = TableStep << 6;
    term    = Q30One;
    pos_sum = Q30One;
    neg_sum = '0;
    for (int n = 1; n <= 24; n++) begin
      term = (term * s30) / (64'(n) << 30);
      if ((n & 1) != 0) begin
        neg_sum = neg_sum + term;
      end else begin
        pos_sum = pos_sum + term;
      end
    end
    ratio = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
    decay_q30[0] = Q30One;
    for (int k = 0; k < int'(Depth); k++) begin
      decay_q30[k+1] = (decay_q30[k] * ratio + (Q30One >> 1)) >> 30;
    end
  endfunction

  // Count times Q.24 rate, truncated to Q.16 and clamped to 48 bits
  function automatic logic [eer_pkg::RateW-1:0] scale_rate(logic [63:0] count,
                                                           logic [63:0] q24);
    logic [127:0] prod;
    prod = (128'(count) * 128'(q24)) >> 8;
    return (prod > 128'(eer_pkg::RateMax)) ? eer_pkg::RateMax : prod[eer_pkg::RateW-1:0];
  endfunction

  // Expected rates of one patch under the current register copy
  function automatic rate_set_t predict_rates(patch_item_t p);
    logic [63:0] dose;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] decay;
    logic [63:0] env;
    logic [63:0] total;
    logic [63:0] omega;
    logic [63:0] mu;
    rate_set_t   r;
    dose = 64'(cfg_shadow[eer_pkg::RegDose]) * 64'(p.load);
    idx  = dose / TableStep;
    frac = dose - idx * TableStep;
    if (idx >= 64'(Depth)) begin
      decay = '0;
    end else begin
      lo    = decay_q30[int'(idx)];
      hi    = decay_q30[int'(idx) + 1];
      decay = lo - ((lo - hi) * frac) / TableStep;
    end
    env   = (64'(cfg_shadow[eer_pkg::RegEnv]) * (Q30One - decay)) >> 30;
    total = 64'(cfg_shadow[eer_pkg::RegContact]) * 64'(p.infected) + env;
    omega = 64'(eer_pkg::EmigrationRateQ24);
    mu    = 64'(cfg_shadow[eer_pkg::RegBaseMort]);
    r.tag               = p.tag;
    r.infection         = scale_rate(64'(p.susceptible), total);
    r.recovery          = scale_rate(64'(p.infected), 64'(cfg_shadow[eer_pkg::RegRecovery]));
    r.susceptible_death = scale_rate(64'(p.susceptible), mu);
    r.infected_death    = scale_rate(64'(p.infected),
                                     mu + 64'(cfg_shadow[eer_pkg::RegDisMort]));
    r.recovered_death   = scale_rate(64'(p.recovered), mu);
    r.shedding          = scale_rate(64'(p.infected), 64'(cfg_shadow[eer_pkg::RegShedding]));
    r.degradation       = scale_rate(64'(p.load), 64'(cfg_shadow[eer_pkg::RegDecay]));
    r.susceptible_leave = scale_rate(64'(p.susceptible), omega);
    r.infected_leave    = scale_rate(64'(p.infected), omega);
    r.recovered_leave   = scale_rate(64'(p.recovered), omega);
    return r;
  endfunction

  task automatic check_field(string name, logic [eer_pkg::RateW-1:0] want,
                             logic [eer_pkg::RateW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 2);
    end else if (r < 92) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(12, 50);
  endfunction

  function automatic logic [eer_pkg::CountW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return eer_pkg::CountW'($urandom_range(0, 255));
      default: return eer_pkg::CountW'($urandom);
    endcase
  endfunction

  function automatic logic [eer_pkg::LoadW-1:0] pick_load();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5: return eer_pkg::LoadW'($urandom_range(0, 300));
      6, 7:    return eer_pkg::LoadW'($urandom_range(0, 1 << 16));
      default: return eer_pkg::LoadW'($urandom);
    endcase
  endfunction

  // Dose steepness leans toward values that keep phi*V inside the table
  function automatic logic [eer_pkg::CfgW-1:0] pick_rate(bit is_dose);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return is_dose ? $urandom_range(1 << 14, 1 << 26) : $urandom_range(0, 1 << 26);
    endcase
  endfunction

  // Offer one patch and hold it until it is taken
  task automatic send_patch(patch_item_t p, logic typed, rate_set_t want);
    typed_wants_q.push_back('{typed, want});
    in_valid_i    <= 1'b1;
    patch_index_i <= p.tag;
    susceptible_i <= p.susceptible;
    infected_i    <= p.infected;
    recovered_i   <= p.recovered;
    virion_load_i <= p.load;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pace(bit burst);
    int gap;
    gap = (burst || $urandom_range(0, 99) < 45) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected result is out
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (typed_wants_q.size() != 0 || expected_rates_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers from one settings row, back to back
  task automatic load_setting(int unsigned sel);
    for (int k = 0; k < 8; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= eer_pkg::cfg_reg_e'(k);
      cfg_data_i  <= settings[sel][k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Track register writes, predict on each taken patch, check each taken result
  always @(posedge clk_i) begin : scoreboard
    preset_t   tw;
    rate_set_t got;
    rate_set_t want;
    patch_item_t cur;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_shadow[cfg_index_i] = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        cur = '{patch_index_i, susceptible_i, infected_i, recovered_i, virion_load_i};
        tw  = typed_wants_q.pop_front();
        expected_rates_q.push_back(tw.typed ? tw.want : predict_rates(cur));
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got = '{patch_tag_o, infection_o, recovery_o, susceptible_death_o, infected_death_o,
                recovered_death_o, shedding_o, degradation_o, susceptible_leave_o,
                infected_leave_o, recovered_leave_o};
        if (expected_rates_q.size() == 0) begin
          $error("result for patch %0d arrived with none expected", patch_tag_o);
          mismatches++;
        end else begin
          want = expected_rates_q.pop_front();
          check_field("patch_tag", eer_pkg::RateW'(want.tag), eer_pkg::RateW'(got.tag));
          check_field("infection", want.infection, got.infection);
          check_field("recovery", want.recovery, got.recovery);
          check_field("susceptible_death", want.susceptible_death, got.susceptible_death);
          check_field("infected_death", want.infected_death, got.infected_death);
          check_field("recovered_death", want.recovered_death, got.recovered_death);
          check_field("shedding", want.shedding, got.shedding);
          check_field("degradation", want.degradation, got.degradation);
          check_field("susceptible_leave", want.susceptible_leave, got.susceptible_leave);
          check_field("infected_leave", want.infected_leave, got.infected_leave);
          check_field("recovered_leave", want.recovered_leave, got.recovered_leave);
        end
      end
    end
  end

  // Result side: free-running stretches, random stalls, and two long hold-offs
  initial begin : sink
    int next_hold;
    next_hold = 150;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (results_seen >= next_hold) begin
        // hold off long enough for the pipeline to back up into the input
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        next_hold = next_hold + 450;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned cur_set;
    bit          burst;
    patch_item_t item;
    build_decay_table();
    for (int k = 0; k < 8; k++) begin
      cfg_shadow[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows, switching settings only with the pipeline empty
    cur_set = 0;
    for (int n = 0; n < NumRows; n++) begin
      if (dir_rows[n].setting != cur_set) begin
        drain_pipeline();
        cur_set = dir_rows[n].setting;
        load_setting(cur_set);
      end
      send_patch(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
      pace(1'b0);
    end

    // Random phases, each under a fresh random setting
    for (int ph = 0; ph < 6; ph++) begin
      drain_pipeline();
      for (int k = 0; k < 8; k++) begin
        settings[ScratchSet][k] = pick_rate(k == eer_pkg::RegDose);
      end
      load_setting(ScratchSet);
      burst = ($urandom_range(0, 2) == 0);
      repeat (150) begin
        item = '{eer_pkg::TagW'($urandom), pick_count(), pick_count(), pick_count(),
                 pick_load()};
        send_patch(item, 1'b0, '0);
        pace(burst);
      end
    end

    drain_pipeline();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
